### rtl/core/hio_pkg.sv
`default_nettype none

package hio_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned REC_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COLL_W   = 11;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned START_W  = 10;
  localparam int unsigned HOME_W   = KEY_W;

  localparam int unsigned SUM_W = ((IDX_W + 1) > (FILL_W + 1)) ? (IDX_W + 1) : (FILL_W + 1);

  localparam logic [START_W-1:0] START_RESET = START_W'(512);
  localparam logic [FILL_W-1:0]  FILL_MAX    = '1;
  localparam logic [COLL_W-1:0]  COLL_MAX    = '1;
  localparam logic [REC_W-1:0]   REC_MAX     = '1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = KEY_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_OFFSET = 1'b0,
    CFG_OVF_START   = 1'b1
  } hio_cfg_e;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HOME  = 3'd0,
    ST_OVF   = 3'd1,
    ST_MISS  = 3'd2,
    ST_FULL  = 3'd3,
    ST_RANGE = 3'd4
  } hio_status_e;

  typedef enum logic [1:0] {
    REC_ZERO  = 2'd0,
    REC_NEXT  = 2'd1,
    REC_ENTRY = 2'd2
  } hio_rec_sel_e;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } hio_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REC_W-1:0]    record_number;
    logic [COLL_W-1:0]   collision_count;
  } hio_out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } hio_entry_t;

  typedef struct packed {
    logic         cap_in;
    logic         calc_hash;
    logic         rd_home;
    logic         rd_scan_start;
    logic         rd_scan_next;
    logic         clr_wr;
    logic         wr_home;
    logic         wr_ovf;
    logic         res_load;
    hio_status_e  res_status;
    hio_rec_sel_e res_rec;
    logic         out_load;
  } hio_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_search;
    logic home_oor;
    logic ent_valid;
    logic ent_match;
    logic ovf_full;
    logic scan_empty;
    logic scan_done;
    logic out_free;
  } hio_sts_t;

endpackage

`default_nettype wire

### rtl/core/hio_datapath.sv
`default_nettype none

module hio_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  hio_pkg::hio_in_t               in_data_i,
  input  wire                            out_stall_i,
  output logic                           out_valid_o,
  output hio_pkg::hio_out_t              out_data_o,
  input  wire                            cfg_we_i,
  input  wire [hio_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [hio_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  hio_pkg::hio_cmd_t              cmd_i,
  output hio_pkg::hio_sts_t              sts_o
);
  import hio_pkg::*;

  logic [KEY_W-1:0]   hash_offset_q;
  logic [START_W-1:0] ovf_start_q;

  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   dist_q;
  logic [HOME_W-1:0]  home_q;
  logic [SUM_W-1:0]   ptr_q;
  logic [IDX_W-1:0]   clr_q;

  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [REC_W-1:0]   next_rec_q, next_rec_d;
  logic [COLL_W-1:0]  coll_q, coll_d;

  hio_entry_t         mem_q [TABLE_DEPTH];
  hio_entry_t         rdata_q;
  hio_entry_t         wdata;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;

  hio_out_t           res_q, res_d;
  hio_out_t           out_q;
  logic               out_valid_q;

  logic [KEY_W-1:0]   dist_in;
  logic [KEY_W:0]     hash_sum;
  logic [SUM_W-1:0]   start_ext, slot, scan_end;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_offset_q <= '0;
      ovf_start_q   <= START_RESET;
    end else if (cfg_we_i) begin
      unique case (hio_cfg_e'(cfg_idx_i))
        CFG_HASH_OFFSET: hash_offset_q <= cfg_data_i[KEY_W-1:0];
        CFG_OVF_START:   ovf_start_q   <= cfg_data_i[START_W-1:0];
        default:         ;
      endcase
    end
  end

  // Hash
  assign dist_in  = (in_data_i.key >= hash_offset_q) ? (in_data_i.key - hash_offset_q)
                                                     : (hash_offset_q - in_data_i.key);
  assign hash_sum = {1'b0, dist_q} + {{(KEY_W-1){1'b0}}, dist_q[1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q   <= in_data_i.operation;
      key_q  <= in_data_i.key;
      dist_q <= dist_in;
    end
    if (cmd_i.calc_hash) begin
      home_q <= hash_sum[KEY_W:1];
    end
  end

  // Overflow area bounds
  assign start_ext = SUM_W'(ovf_start_q);
  assign slot      = start_ext + SUM_W'(fill_q);
  assign scan_end  = (slot >= SUM_W'(TABLE_DEPTH)) ? SUM_W'(TABLE_DEPTH) : slot;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_scan_start) begin
      ptr_q <= start_ext + SUM_W'(1);
    end else if (cmd_i.rd_scan_next) begin
      ptr_q <= ptr_q + SUM_W'(1);
    end
  end

  // Counters
  always_comb begin
    fill_d     = fill_q;
    next_rec_d = next_rec_q;
    coll_d     = coll_q;
    if (cmd_i.wr_home || cmd_i.wr_ovf) begin
      if (next_rec_q != REC_MAX) next_rec_d = next_rec_q + REC_W'(1);
    end
    if (cmd_i.wr_ovf) begin
      fill_d = fill_q + FILL_W'(1);
      if (coll_q != COLL_MAX) coll_d = coll_q + COLL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      next_rec_q <= '0;
      coll_q     <= '0;
      clr_q      <= '0;
    end else begin
      fill_q     <= fill_d;
      next_rec_q <= next_rec_d;
      coll_q     <= coll_d;
      if (cmd_i.clr_wr) clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Table memory
  always_comb begin
    we    = cmd_i.clr_wr || cmd_i.wr_home || cmd_i.wr_ovf;
    waddr = slot[IDX_W-1:0];
    if (cmd_i.clr_wr)       waddr = clr_q;
    else if (cmd_i.wr_home) waddr = home_q[IDX_W-1:0];
    wdata = '0;
    if (!cmd_i.clr_wr) begin
      wdata.valid = 1'b1;
      wdata.key   = key_q;
      wdata.rec   = next_rec_q;
    end
    raddr = ptr_q[IDX_W-1:0];
    if (cmd_i.rd_home)            raddr = home_q[IDX_W-1:0];
    else if (cmd_i.rd_scan_start) raddr = start_ext[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.rd_home || cmd_i.rd_scan_start || cmd_i.rd_scan_next) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result
  always_comb begin
    res_d.status          = cmd_i.res_status;
    res_d.collision_count = coll_d;
    case (cmd_i.res_rec)
      REC_NEXT:  res_d.record_number = next_rec_q;
      REC_ENTRY: res_d.record_number = rdata_q.rec;
      default:   res_d.record_number = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) res_q <= res_d;
    if (cmd_i.out_load) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status
  assign sts_o.clr_last   = (clr_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.op_search  = (op_q == OP_SEARCH);
  assign sts_o.home_oor   = (home_q >= HOME_W'(TABLE_DEPTH));
  assign sts_o.ent_valid  = rdata_q.valid;
  assign sts_o.ent_match  = (rdata_q.key == key_q);
  assign sts_o.ovf_full   = (slot >= SUM_W'(TABLE_DEPTH)) || (fill_q == FILL_MAX);
  assign sts_o.scan_empty = (start_ext >= scan_end);
  assign sts_o.scan_done  = (ptr_q >= scan_end);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

### rtl/core/hio_ctrl.sv
`default_nettype none

module hio_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  hio_pkg::hio_sts_t  sts_i,
  output hio_pkg::hio_cmd_t  cmd_o
);
  import hio_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_LOOK  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_RESP  = 7'b1000000
  } hio_state_e;

  hio_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        cmd_o.calc_hash = 1'b1;
        state_d         = S_LOOK;
      end
      S_LOOK: begin
        if (sts_i.home_oor) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_RANGE;
          cmd_o.res_rec    = REC_ZERO;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_home = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_RESP;
        if (!sts_i.op_search) begin
          cmd_o.res_load = 1'b1;
          if (!sts_i.ent_valid) begin
            cmd_o.wr_home    = 1'b1;
            cmd_o.res_status = ST_HOME;
            cmd_o.res_rec    = REC_NEXT;
          end else if (sts_i.ovf_full) begin
            cmd_o.res_status = ST_FULL;
            cmd_o.res_rec    = REC_ZERO;
          end else begin
            cmd_o.wr_ovf     = 1'b1;
            cmd_o.res_status = ST_OVF;
            cmd_o.res_rec    = REC_NEXT;
          end
        end else if (!sts_i.ent_valid) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISS;
          cmd_o.res_rec    = REC_ZERO;
        end else if (sts_i.ent_match) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_HOME;
          cmd_o.res_rec    = REC_ENTRY;
        end else if (sts_i.scan_empty) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISS;
          cmd_o.res_rec    = REC_ZERO;
        end else begin
          cmd_o.rd_scan_start = 1'b1;
          state_d             = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.ent_valid && sts_i.ent_match) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OVF;
          cmd_o.res_rec    = REC_ENTRY;
          state_d          = S_RESP;
        end else if (sts_i.scan_done) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISS;
          cmd_o.res_rec    = REC_ZERO;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_scan_next = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken beat");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clr_wr, cmd_o.wr_home, cmd_o.wr_ovf}))
    else $error("conflicting table writes");

  a_ovf_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_ovf |-> !sts_i.ovf_full)
    else $error("overflow append into a full area");

  a_home_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_home || cmd_o.rd_home) |-> !sts_i.home_oor)
    else $error("home slot access out of range");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_scan_next |-> !sts_i.scan_done)
    else $error("scan read past the filled area");

endmodule

`default_nettype wire

### rtl/core/hash_index_overflow_area.sv
`default_nettype none

// channel | handshake                 | payload
// --------+---------------------------+------------------------------------------
// in      | in_valid_i / in_stall_o   | in_data_i  {operation, key}
// out     | out_valid_o / out_stall_i | out_data_o {status, record_number, coll}
// cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One item at a time. Insert, home hit, empty home: HASH, LOOK, CHECK, RESP states,
// then beat valid and next item taken together (no CHECK for out-of-range home).
// A search that misses a taken home slot scans the overflow area through the
// single table read port, one entry per cycle, up to overflow_fill entries.
// After reset a clearing pass writes all TABLE_DEPTH (1024) table entries,
// with in_stall_o high; cfg writes are taken meanwhile.
// The output register holds a stalled beat; the next item is accepted meanwhile
// and its result waits until the held beat is taken.

module hash_index_overflow_area (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  hio_pkg::hio_in_t               in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output hio_pkg::hio_out_t              out_data_o,
  input  wire                            cfg_we_i,
  input  wire [hio_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [hio_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hio_pkg::*;

  hio_cmd_t cmd;
  hio_sts_t sts;

  hio_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hio_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
